### rtl/vgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vgc_pkg;

	// Fixed field widths
	localparam int COORD_W = 32;
	localparam int LEAF_W  = 31;
	localparam int SUM_W   = 56;
	localparam int CNT_W   = 24;
	localparam int IDX_W   = 8;
	localparam int USED_W  = 9;
	localparam int STAT_W  = 3;
	localparam int REQ_W   = 2;

	// Stream payload widths (packed, padded to whole bytes)
	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 136;

	localparam logic [LEAF_W-1:0] LEAF_RESET = 31'd655;
	localparam logic [CNT_W-1:0]  COUNT_MAX  = 24'hFFFFFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_READ   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ADDED      = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_KEY_RANGE  = 3'd2,
		ST_COUNT_FULL = 3'd3,
		ST_READ_OK    = 3'd4,
		ST_EMPTY      = 3'd5,
		ST_CLEARED    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	// Controller to datapath
	typedef struct packed {
		logic    in_load;
		logic    div_start;
		logic    div_cent;
		logic    res_store;
		logic    search_start;
		logic    search_run;
		logic    update;
		logic    rd_latch;
		logic    clear;
		logic    status_set;
		status_t status;
		axis_t   axis;
		logic    out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic key_bad;
		logic hit;
		logic miss;
		logic rd_ok;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/vgc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/vgc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, result floored.
module vgc_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [vgc_pkg::SUM_W-1:0]  dividend,
	input  wire logic [vgc_pkg::LEAF_W-1:0]        divisor,
	output logic                                   done,
	output logic signed [vgc_pkg::SUM_W-1:0]       quotient
);

	localparam int SW = vgc_pkg::SUM_W;
	localparam int LW = vgc_pkg::LEAF_W;
	localparam int CW = $clog2(SW);
	localparam logic [CW-1:0] LAST = CW'(SW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] mag_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] d_q;
	logic          neg_q;

	logic [LW:0]   trial;
	logic          ge;
	logic [LW:0]   diff;

	// Shift-subtract step
	always_comb begin
		trial = {rem_q, mag_q[SW-1]};
		ge    = trial >= {1'b0, d_q};
		diff  = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			mag_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SW-2:0], ge};
			rem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
		end
	end

	// Floor correction for negative dividends
	always_comb begin
		if (!neg_q) begin
			quotient = mag_q;
		end else if (rem_q != '0) begin
			quotient = ~mag_q;
		end else begin
			quotient = -mag_q;
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

### rtl/vgc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vgc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire vgc_pkg::req_t  in_req,
	output logic                in_ready,
	input  wire vgc_pkg::stat_t stat,
	output vgc_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_KDIV,
		S_KWAIT,
		S_KCHK,
		S_SEARCH,
		S_UPDATE,
		S_RCHK,
		S_RLATCH,
		S_CDIV,
		S_CWAIT,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t          state_q;
	vgc_pkg::axis_t  axis_q;

	assign in_ready = (state_q == S_IDLE);

	// Command decode
	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		case (state_q)
			S_IDLE:   cmd.in_load = in_valid;
			S_KDIV:   cmd.div_start = 1'b1;
			S_KWAIT:  cmd.res_store = stat.div_done;
			S_KCHK: begin
				if (stat.key_bad) begin
					cmd.status_set = 1'b1;
					cmd.status     = vgc_pkg::ST_KEY_RANGE;
				end else begin
					cmd.search_start = 1'b1;
				end
			end
			S_SEARCH: cmd.search_run = 1'b1;
			S_UPDATE: cmd.update = 1'b1;
			S_RCHK: begin
				if (!stat.rd_ok) begin
					cmd.status_set = 1'b1;
					cmd.status     = vgc_pkg::ST_EMPTY;
				end
			end
			S_RLATCH: cmd.rd_latch = 1'b1;
			S_CDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_cent  = 1'b1;
			end
			S_CWAIT: begin
				cmd.div_cent  = 1'b1;
				cmd.res_store = stat.div_done;
				if (stat.div_done && axis_q == vgc_pkg::AX_Z) begin
					cmd.status_set = 1'b1;
					cmd.status     = vgc_pkg::ST_READ_OK;
				end
			end
			S_CLEAR: begin
				cmd.clear      = 1'b1;
				cmd.status_set = 1'b1;
				cmd.status     = vgc_pkg::ST_CLEARED;
			end
			S_DONE:   cmd.out_load = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= vgc_pkg::AX_X;
		end else begin
			case (state_q)
				S_IDLE: begin
					axis_q <= vgc_pkg::AX_X;
					if (in_valid) begin
						case (in_req)
							vgc_pkg::REQ_INSERT: state_q <= S_KDIV;
							vgc_pkg::REQ_READ:   state_q <= S_RCHK;
							vgc_pkg::REQ_CLEAR:  state_q <= S_CLEAR;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_KDIV:   state_q <= S_KWAIT;
				S_KWAIT: begin
					if (stat.div_done) begin
						if (axis_q == vgc_pkg::AX_Z) begin
							state_q <= S_KCHK;
						end else begin
							axis_q  <= vgc_pkg::axis_t'(axis_q + 2'd1);
							state_q <= S_KDIV;
						end
					end
				end
				S_KCHK:   state_q <= stat.key_bad ? S_DONE : S_SEARCH;
				S_SEARCH: begin
					if (stat.hit || stat.miss) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: state_q <= S_DONE;
				S_RCHK:   state_q <= stat.rd_ok ? S_RLATCH : S_DONE;
				S_RLATCH: state_q <= S_CDIV;
				S_CDIV:   state_q <= S_CWAIT;
				S_CWAIT: begin
					if (stat.div_done) begin
						if (axis_q == vgc_pkg::AX_Z) begin
							state_q <= S_DONE;
						end else begin
							axis_q  <= vgc_pkg::axis_t'(axis_q + 2'd1);
							state_q <= S_CDIV;
						end
					end
				end
				S_CLEAR:  state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/vgc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module vgc_dp #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BITS    = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire vgc_pkg::cmd_t                          cmd,
	output vgc_pkg::stat_t                              stat,
	input  wire logic [vgc_pkg::COORD_W-1:0]            in_x,
	input  wire logic [vgc_pkg::COORD_W-1:0]            in_y,
	input  wire logic [vgc_pkg::COORD_W-1:0]            in_z,
	input  wire logic [vgc_pkg::IDX_W-1:0]              in_idx,
	input  wire logic                                   cfg_we,
	input  wire logic [vgc_pkg::LEAF_W-1:0]             cfg_wdata,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output vgc_pkg::status_t                            out_status,
	output logic [vgc_pkg::COORD_W-1:0]                 out_cx,
	output logic [vgc_pkg::COORD_W-1:0]                 out_cy,
	output logic [vgc_pkg::COORD_W-1:0]                 out_cz,
	output logic [vgc_pkg::CNT_W-1:0]                   out_pts,
	output logic [vgc_pkg::USED_W-1:0]                  out_used
);

	localparam int CW   = vgc_pkg::COORD_W;
	localparam int SW   = vgc_pkg::SUM_W;
	localparam int NW   = vgc_pkg::CNT_W;
	localparam int LW   = vgc_pkg::LEAF_W;
	localparam int KW   = 3 * KEY_BITS;
	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW   = $clog2(TABLE_DEPTH + 1);
	localparam int WW   = KW + 3 * SW + NW;
	localparam int SZ_LO = NW;
	localparam int SY_LO = NW + SW;
	localparam int SX_LO = NW + 2 * SW;
	localparam int K_LO  = NW + 3 * SW;
	localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

	// Item and config registers
	logic [LW-1:0]        leaf_q;
	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic [vgc_pkg::IDX_W-1:0] idx_q;
	logic [KW-1:0]        key_q;
	logic                 bad_q;
	logic [UW-1:0]        used_q;
	vgc_pkg::status_t     status_q;
	logic [CW-1:0]        cx_q, cy_q, cz_q;

	// Search and entry registers
	logic [UW-1:0]        scan_q;
	logic                 cmp_valid_q;
	logic [AW-1:0]        cmp_idx_q;
	logic                 found_q;
	logic [AW-1:0]        hit_idx_q;
	logic [WW-1:0]        ent_q;

	// Output register
	logic                 out_valid_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WW-1:0]        ram_rdata;

	logic                 div_done;
	logic signed [SW-1:0] div_q;
	logic signed [SW-1:0] div_num;
	logic [LW-1:0]        div_den;
	logic                 q_range_ok;
	logic signed [SW-1:0] ext_x, ext_y, ext_z;

	vgc_ram #(
		.WIDTH(WW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	vgc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	assign ext_x = {{(SW - CW){px_q[CW-1]}}, px_q};
	assign ext_y = {{(SW - CW){py_q[CW-1]}}, py_q};
	assign ext_z = {{(SW - CW){pz_q[CW-1]}}, pz_q};

	// Divider operand select
	always_comb begin
		if (cmd.div_cent) begin
			div_den = LW'(ent_q[NW-1:0]);
			case (cmd.axis)
				vgc_pkg::AX_X: div_num = ent_q[SX_LO +: SW];
				vgc_pkg::AX_Y: div_num = ent_q[SY_LO +: SW];
				default:       div_num = ent_q[SZ_LO +: SW];
			endcase
		end else begin
			div_den = (leaf_q == '0) ? LW'(1) : leaf_q;
			case (cmd.axis)
				vgc_pkg::AX_X: div_num = ext_x;
				vgc_pkg::AX_Y: div_num = ext_y;
				default:       div_num = ext_z;
			endcase
		end
	end

	// Key field must fit signed KEY_BITS
	assign q_range_ok = (div_q[SW-1:KEY_BITS-1] == '0) || (div_q[SW-1:KEY_BITS-1] == '1);

	// Read address: scan pointer while searching, else requested entry
	assign ram_raddr = cmd.search_run ? scan_q[AW-1:0] : AW'(idx_q);

	// Table write on update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(used_q);
		ram_wdata = {key_q, ext_x, ext_y, ext_z, NW'(1)};
		if (cmd.update) begin
			if (found_q) begin
				ram_waddr = hit_idx_q;
				ram_we    = (ent_q[NW-1:0] != vgc_pkg::COUNT_MAX);
				ram_wdata = {key_q,
					SW'(ent_q[SX_LO +: SW] + ext_x),
					SW'(ent_q[SY_LO +: SW] + ext_y),
					SW'(ent_q[SZ_LO +: SW] + ext_z),
					NW'(ent_q[NW-1:0] + 1'b1)};
			end else begin
				ram_we = (used_q < DEPTH_U);
			end
		end
	end

	assign stat.div_done = div_done;
	assign stat.key_bad  = bad_q;
	assign stat.hit      = cmp_valid_q && (ram_rdata[K_LO +: KW] == key_q);
	assign stat.miss     = !cmp_valid_q && (scan_q >= used_q);
	assign stat.rd_ok    = 32'(idx_q) < 32'(used_q);
	assign stat.out_free = !out_valid_q || out_ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q      <= vgc_pkg::LEAF_RESET;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			cmp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			scan_q      <= '0;
		end else begin
			if (cfg_we) begin
				leaf_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				used_q <= '0;
			end else if (cmd.update && !found_q && used_q < DEPTH_U) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Pipelined scan: address out, key compare in the following cycle
			if (cmd.search_start) begin
				scan_q      <= '0;
				cmp_valid_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (cmd.search_run) begin
				cmp_valid_q <= scan_q < used_q;
				if (scan_q < used_q) begin
					scan_q <= scan_q + 1'b1;
				end
				if (stat.hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			px_q  <= in_x;
			py_q  <= in_y;
			pz_q  <= in_z;
			idx_q <= in_idx;
			bad_q <= 1'b0;
		end
		if (cmd.res_store) begin
			if (cmd.div_cent) begin
				case (cmd.axis)
					vgc_pkg::AX_X: cx_q <= div_q[CW-1:0];
					vgc_pkg::AX_Y: cy_q <= div_q[CW-1:0];
					default:       cz_q <= div_q[CW-1:0];
				endcase
			end else begin
				bad_q <= bad_q | !q_range_ok;
				case (cmd.axis)
					vgc_pkg::AX_X: key_q[2*KEY_BITS +: KEY_BITS] <= div_q[KEY_BITS-1:0];
					vgc_pkg::AX_Y: key_q[KEY_BITS +: KEY_BITS]   <= div_q[KEY_BITS-1:0];
					default:       key_q[0 +: KEY_BITS]          <= div_q[KEY_BITS-1:0];
				endcase
			end
		end
		if (cmd.search_run) begin
			cmp_idx_q <= scan_q[AW-1:0];
			if (stat.hit) begin
				ent_q     <= ram_rdata;
				hit_idx_q <= cmp_idx_q;
			end
		end
		if (cmd.rd_latch) begin
			ent_q <= ram_rdata;
		end
		if (cmd.status_set) begin
			status_q <= cmd.status;
		end else if (cmd.update) begin
			if (found_q) begin
				status_q <= (ent_q[NW-1:0] == vgc_pkg::COUNT_MAX) ?
					vgc_pkg::ST_COUNT_FULL : vgc_pkg::ST_ADDED;
			end else begin
				status_q <= (used_q < DEPTH_U) ?
					vgc_pkg::ST_ADDED : vgc_pkg::ST_TABLE_FULL;
			end
		end
		if (cmd.out_load) begin
			out_status <= status_q;
			out_used   <= vgc_pkg::USED_W'(used_q);
			if (status_q == vgc_pkg::ST_READ_OK) begin
				out_cx  <= cx_q;
				out_cy  <= cy_q;
				out_cz  <= cz_q;
				out_pts <= ent_q[NW-1:0];
			end else begin
				out_cx  <= '0;
				out_cy  <= '0;
				out_cz  <= '0;
				out_pts <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/voxel_grid_centroid_filter.sv
// Insert: 3 key divisions, a table scan of the used entries and control steps.
// Read: 3 centroid divisions plus control steps.
// One item is worked on at a time, paced by the one shared bit-serial divider
//   and the single read port of the table memory.
// Reset clears the entry count, leaf size (to 655) and all control; the table
//   memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module voxel_grid_centroid_filter #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BITS    = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [vgc_pkg::LEAF_W-1:0]        cfg_wdata,     // voxel edge length
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64], entry_index[103:96]
	input  wire logic [vgc_pkg::S_DATA_W-1:0]      s_axis_tdata,
	input  wire logic [vgc_pkg::REQ_W-1:0]         s_axis_tuser,  // req_type
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// centroid_x[31:0], centroid_y[63:32], centroid_z[95:64],
	// voxel_points[119:96], voxels_used[128:120], zero pad above
	output logic [vgc_pkg::M_DATA_W-1:0]           m_axis_tdata,
	output logic [vgc_pkg::STAT_W-1:0]             m_axis_tuser   // status
);

	vgc_pkg::cmd_t    cmd;
	vgc_pkg::stat_t   stat;
	vgc_pkg::status_t out_status;
	logic [vgc_pkg::COORD_W-1:0] out_cx, out_cy, out_cz;
	logic [vgc_pkg::CNT_W-1:0]   out_pts;
	logic [vgc_pkg::USED_W-1:0]  out_used;

	vgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_req   (vgc_pkg::req_t'(s_axis_tuser)),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vgc_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS   (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_x       (s_axis_tdata[31:0]),
		.in_y       (s_axis_tdata[63:32]),
		.in_z       (s_axis_tdata[95:64]),
		.in_idx     (s_axis_tdata[103:96]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (out_status),
		.out_cx     (out_cx),
		.out_cy     (out_cy),
		.out_cz     (out_cz),
		.out_pts    (out_pts),
		.out_used   (out_used)
	);

	assign m_axis_tdata = {7'd0, out_used, out_pts, out_cz, out_cy, out_cx};
	assign m_axis_tuser = out_status;

`ifndef NO_ASSERTIONS
	// A real request keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser != vgc_pkg::REQ_NONE)
		|=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// Only a successful read carries centroid and count data
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != vgc_pkg::ST_READ_OK)
		|-> (m_axis_tdata[119:0] == '0))
		else $error("nonzero payload on a non-read result");

	// A cleared table reports zero entries
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == vgc_pkg::ST_CLEARED)
		|-> (m_axis_tdata[128:120] == '0))
		else $error("clear result shows used entries");
`endif

endmodule

`default_nettype wire
